// ===== src/tfms_pkg.sv =====
// ----------------------------------------------------------------------------
// tfms_pkg
// Shared types and constants for the thruster force and moment summer.
// ----------------------------------------------------------------------------
`default_nettype none

package tfms_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned SUM_W  = 48;

    // configuration register indexes
    localparam logic [1:0] REG_TIME_NOW = 2'd0;
    localparam logic [1:0] REG_CG_X     = 2'd1;
    localparam logic [1:0] REG_CG_Y     = 2'd2;
    localparam logic [1:0] REG_CG_Z     = 2'd3;
    localparam int unsigned CFG_IDX_W   = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRAC,
        ST_FRC_X,
        ST_FRC_Y,
        ST_FRC_Z,
        ST_MOM_0,
        ST_MOM_1,
        ST_MOM_2,
        ST_MOM_3,
        ST_MOM_4,
        ST_MOM_5,
        ST_ACC,
        ST_OUT
    } state_t;

    // multiplier operand selection
    typedef enum logic [3:0] {
        MUL_FRAC,
        MUL_FX,
        MUL_FY,
        MUL_FZ,
        MUL_R1F2,
        MUL_R2F1,
        MUL_R2F0,
        MUL_R0F2,
        MUL_R0F1,
        MUL_R1F0
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t sel;
        logic     acc;
        logic     out_load;
        logic     clear;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic last;
    } status_t;

endpackage

`default_nettype wire

// ===== src/tfms_if.sv =====
// ----------------------------------------------------------------------------
// tfms_if
// Valid/ready channel interfaces for thruster items, results and config.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfms_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] fire_time;
    logic [31:0] burn_time;
    logic [31:0] decay_rate;
    logic signed [31:0] thrust_x;
    logic signed [31:0] thrust_y;
    logic signed [31:0] thrust_z;
    logic signed [31:0] mount_x;
    logic signed [31:0] mount_y;
    logic signed [31:0] mount_z;
    logic        last_one;
    modport source (output valid, fire_time, burn_time, decay_rate, thrust_x, thrust_y,
                    thrust_z, mount_x, mount_y, mount_z, last_one, input ready);
    modport sink (input valid, fire_time, burn_time, decay_rate, thrust_x, thrust_y,
                  thrust_z, mount_x, mount_y, mount_z, last_one, output ready);
endinterface

interface tfms_out_if;
    logic        valid;
    logic        ready;
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic signed [47:0] moment_x;
    logic signed [47:0] moment_y;
    logic signed [47:0] moment_z;
    modport source (output valid, force_x, force_y, force_z, moment_x, moment_y,
                    moment_z, input ready);
    modport sink (input valid, force_x, force_y, force_z, moment_x, moment_y,
                  moment_z, output ready);
endinterface

interface tfms_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/tfms_ctrl.sv =====
// ----------------------------------------------------------------------------
// tfms_ctrl
// Sequencer stepping one thruster item through the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module tfms_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              out_busy,
    input  wire tfms_pkg::status_t status,
    output tfms_pkg::cmd_t         cmd
);

    tfms_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tfms_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tfms_pkg::ST_IDLE:  if (in_valid) state_next = tfms_pkg::ST_FRAC;
            tfms_pkg::ST_FRAC:  state_next = tfms_pkg::ST_FRC_X;
            tfms_pkg::ST_FRC_X:
                state_next = status.active ? tfms_pkg::ST_FRC_Y : tfms_pkg::ST_ACC;
            tfms_pkg::ST_FRC_Y: state_next = tfms_pkg::ST_FRC_Z;
            tfms_pkg::ST_FRC_Z: state_next = tfms_pkg::ST_MOM_0;
            tfms_pkg::ST_MOM_0: state_next = tfms_pkg::ST_MOM_1;
            tfms_pkg::ST_MOM_1: state_next = tfms_pkg::ST_MOM_2;
            tfms_pkg::ST_MOM_2: state_next = tfms_pkg::ST_MOM_3;
            tfms_pkg::ST_MOM_3: state_next = tfms_pkg::ST_MOM_4;
            tfms_pkg::ST_MOM_4: state_next = tfms_pkg::ST_MOM_5;
            tfms_pkg::ST_MOM_5: state_next = tfms_pkg::ST_ACC;
            tfms_pkg::ST_ACC:
                state_next = status.last ? tfms_pkg::ST_OUT : tfms_pkg::ST_IDLE;
            tfms_pkg::ST_OUT:   if (!out_busy) state_next = tfms_pkg::ST_IDLE;
            default:            state_next = tfms_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        cmd.sel  = tfms_pkg::MUL_FRAC;
        in_ready = 1'b0;
        case (state_reg)
            tfms_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            tfms_pkg::ST_FRAC:  begin cmd.mul_en = 1'b1; cmd.sel = tfms_pkg::MUL_FRAC; end
            tfms_pkg::ST_FRC_X: begin cmd.mul_en = 1'b1; cmd.sel = tfms_pkg::MUL_FX; end
            tfms_pkg::ST_FRC_Y: begin cmd.mul_en = 1'b1; cmd.sel = tfms_pkg::MUL_FY; end
            tfms_pkg::ST_FRC_Z: begin cmd.mul_en = 1'b1; cmd.sel = tfms_pkg::MUL_FZ; end
            tfms_pkg::ST_MOM_0: begin cmd.mul_en = 1'b1; cmd.sel = tfms_pkg::MUL_R1F2; end
            tfms_pkg::ST_MOM_1: begin cmd.mul_en = 1'b1; cmd.sel = tfms_pkg::MUL_R2F1; end
            tfms_pkg::ST_MOM_2: begin cmd.mul_en = 1'b1; cmd.sel = tfms_pkg::MUL_R2F0; end
            tfms_pkg::ST_MOM_3: begin cmd.mul_en = 1'b1; cmd.sel = tfms_pkg::MUL_R0F2; end
            tfms_pkg::ST_MOM_4: begin cmd.mul_en = 1'b1; cmd.sel = tfms_pkg::MUL_R0F1; end
            tfms_pkg::ST_MOM_5: begin cmd.mul_en = 1'b1; cmd.sel = tfms_pkg::MUL_R1F0; end
            tfms_pkg::ST_ACC:   cmd.acc = 1'b1;
            tfms_pkg::ST_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // an item is taken only while idle
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == tfms_pkg::ST_IDLE)
        else $error("ready outside idle");
    // load and output commands never coincide
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.out_load))
        else $error("load with output");
    // accumulate is followed by idle or output
    a_acc_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc |=> (state_reg == tfms_pkg::ST_IDLE || state_reg == tfms_pkg::ST_OUT))
        else $error("bad state after accumulate");

endmodule

`default_nettype wire

// ===== src/tfms_datapath.sv =====
// ----------------------------------------------------------------------------
// tfms_datapath
// Operand registers, shared multiplier, partial terms and saturating sums.
// ----------------------------------------------------------------------------
`default_nettype none

module tfms_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tfms_pkg::cmd_t     cmd,
    output tfms_pkg::status_t       status,
    input  wire logic [31:0]        time_now,
    input  wire logic signed [31:0] cg_x,
    input  wire logic signed [31:0] cg_y,
    input  wire logic signed [31:0] cg_z,
    input  wire logic [31:0]        fire_time,
    input  wire logic [31:0]        burn_time,
    input  wire logic [31:0]        decay_rate,
    input  wire logic signed [31:0] thrust_x,
    input  wire logic signed [31:0] thrust_y,
    input  wire logic signed [31:0] thrust_z,
    input  wire logic signed [31:0] mount_x,
    input  wire logic signed [31:0] mount_y,
    input  wire logic signed [31:0] mount_z,
    input  wire logic               last_one,
    output logic signed [47:0]      sum_f [3],
    output logic signed [47:0]      sum_m [3]
);

    localparam logic signed [48:0] SMAX = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [48:0] SMIN = -49'sh0_8000_0000_0000;

    logic        fired_reg, last_reg, rate_nz_reg, dpos_reg, dbig_reg;
    logic [31:0] d_reg, rate_reg;
    logic signed [31:0] thr_reg [3];
    logic signed [32:0] arm_reg [3];
    logic [32:0] frac_reg;
    logic signed [32:0] frc_reg [3];
    logic signed [48:0] mom_reg [3];
    logic signed [47:0] sf_reg [3];
    logic signed [47:0] sm_reg [3];
    logic signed [33:0] d_full;

    assign d_full = $signed({2'b00, fire_time}) + $signed({2'b00, burn_time})
                  - $signed({2'b00, time_now});

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fired_reg   <= fire_time != '0;
            last_reg    <= last_one;
            rate_nz_reg <= decay_rate != '0;
            dpos_reg    <= d_full > 34'sd0;
            dbig_reg    <= d_full[33:32] != 2'b00 && !d_full[33];
            d_reg       <= d_full[31:0];
            rate_reg    <= decay_rate;
            thr_reg[0]  <= thrust_x;
            thr_reg[1]  <= thrust_y;
            thr_reg[2]  <= thrust_z;
            arm_reg[0]  <= 33'(cg_x) - 33'(mount_x);
            arm_reg[1]  <= 33'(cg_y) - 33'(mount_y);
            arm_reg[2]  <= 33'(cg_z) - 33'(mount_z);
        end
    end

    // shared multiplier operand selection: 34 x 34 signed
    logic signed [33:0] op_a, op_b;
    logic signed [67:0] prod;
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.sel)
            tfms_pkg::MUL_FRAC: begin op_a = {2'b00, d_reg}; op_b = {2'b00, rate_reg}; end
            tfms_pkg::MUL_FX:   begin op_a = 34'(thr_reg[0]); op_b = {1'b0, frac_reg}; end
            tfms_pkg::MUL_FY:   begin op_a = 34'(thr_reg[1]); op_b = {1'b0, frac_reg}; end
            tfms_pkg::MUL_FZ:   begin op_a = 34'(thr_reg[2]); op_b = {1'b0, frac_reg}; end
            tfms_pkg::MUL_R1F2: begin op_a = 34'(arm_reg[1]); op_b = 34'(frc_reg[2]); end
            tfms_pkg::MUL_R2F1: begin op_a = 34'(arm_reg[2]); op_b = 34'(frc_reg[1]); end
            tfms_pkg::MUL_R2F0: begin op_a = 34'(arm_reg[2]); op_b = 34'(frc_reg[0]); end
            tfms_pkg::MUL_R0F2: begin op_a = 34'(arm_reg[0]); op_b = 34'(frc_reg[2]); end
            tfms_pkg::MUL_R0F1: begin op_a = 34'(arm_reg[0]); op_b = 34'(frc_reg[1]); end
            tfms_pkg::MUL_R1F0: begin op_a = 34'(arm_reg[1]); op_b = 34'(frc_reg[0]); end
            default: ;
        endcase
    end
    assign prod = op_a * op_b;

    // cross terms floored to Q32.16 (arithmetic shift floors)
    logic signed [48:0] term;
    assign term = 49'(prod >>> 16);

    // fraction, scaled force and moment registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            case (cmd.sel)
                tfms_pkg::MUL_FRAC:
                begin
                    if (!fired_reg || !dpos_reg || !rate_nz_reg)
                        frac_reg <= '0;
                    else if (dbig_reg || prod[67:32] != '0)
                        frac_reg <= 33'h1_0000_0000;
                    else
                        frac_reg <= prod[32:0];
                end
                tfms_pkg::MUL_FX:   frc_reg[0] <= 33'(prod >>> 32);
                tfms_pkg::MUL_FY:   frc_reg[1] <= 33'(prod >>> 32);
                tfms_pkg::MUL_FZ:   frc_reg[2] <= 33'(prod >>> 32);
                tfms_pkg::MUL_R1F2: mom_reg[0] <= term;
                tfms_pkg::MUL_R2F1: mom_reg[0] <= mom_reg[0] - term;
                tfms_pkg::MUL_R2F0: mom_reg[1] <= term;
                tfms_pkg::MUL_R0F2: mom_reg[1] <= mom_reg[1] - term;
                tfms_pkg::MUL_R0F1: mom_reg[2] <= term;
                tfms_pkg::MUL_R1F0: mom_reg[2] <= mom_reg[2] - term;
                default: ;
            endcase
        end
    end

    function automatic logic signed [47:0] sat(input logic signed [49:0] v);
        if (v > 50'(SMAX))      sat = SMAX[47:0];
        else if (v < 50'(SMIN)) sat = SMIN[47:0];
        else                    sat = v[47:0];
    endfunction

    // saturating sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sf_reg[k] <= '0;
                sm_reg[k] <= '0;
            end
        end
        else if (cmd.clear)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sf_reg[k] <= '0;
                sm_reg[k] <= '0;
            end
        end
        else if (cmd.acc && frac_reg != '0)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sf_reg[k] <= sat(50'(sf_reg[k]) + 50'(frc_reg[k]));
                sm_reg[k] <= sat(50'(sm_reg[k]) + 50'(mom_reg[k]));
            end
        end
    end

    assign status.active = frac_reg != '0;
    assign status.last   = last_reg;
    assign sum_f = sf_reg;
    assign sum_m = sm_reg;

endmodule

`default_nettype wire

// ===== src/thruster_force_moment_sum.sv =====
// ----------------------------------------------------------------------------
// thruster_force_moment_sum
// Sums thrust force and moment about cg over the thrusters of one evaluation.
// ----------------------------------------------------------------------------
// Usage:
//   cfg: write time_now (0) and cg_x/y/z (1..3) while the block is idle.
//   in:  one thruster per transfer; last_one closes the evaluation.
//   out: one transfer of force and moment sums after each last_one item.
// Sequence: one 34x34 multiplier is shared. A fired thruster with nonzero
//   fraction steps through fraction, three forces, six cross terms,
//   accumulate and idle; an unfired or spent one goes from the x force
//   to accumulate. A last item then loads the output register, waiting while it is full.
// Reset clears the sums, the configuration registers and the output valid.
// A stalled receiver holds the result; further items are accepted until a
// new result would need the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module thruster_force_moment_sum (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tfms_cfg_if.sink   cfg,
    tfms_in_if.sink    in,
    tfms_out_if.source out
);

    logic [31:0]        time_now_reg;
    logic signed [31:0] cg_reg [3];
    logic               ov_reg;
    logic signed [47:0] sum_f [3];
    logic signed [47:0] sum_m [3];
    tfms_pkg::cmd_t     cmd;
    tfms_pkg::status_t  status;

    // configuration registers
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now_reg <= '0;
            cg_reg[0]    <= '0;
            cg_reg[1]    <= '0;
            cg_reg[2]    <= '0;
        end
        else if (cfg.valid && cfg.index[7:2] == '0)
        begin
            case (cfg.index[1:0])
                tfms_pkg::REG_TIME_NOW: time_now_reg <= cfg.data;
                tfms_pkg::REG_CG_X:     cg_reg[0] <= cfg.data;
                tfms_pkg::REG_CG_Y:     cg_reg[1] <= cfg.data;
                tfms_pkg::REG_CG_Z:     cg_reg[2] <= cfg.data;
                default: ;
            endcase
        end
    end

    tfms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in.valid),
        .in_ready (in.ready),
        .out_busy (ov_reg && !out.ready),
        .status   (status),
        .cmd      (cmd)
    );

    tfms_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .time_now   (time_now_reg),
        .cg_x       (cg_reg[0]),
        .cg_y       (cg_reg[1]),
        .cg_z       (cg_reg[2]),
        .fire_time  (in.fire_time),
        .burn_time  (in.burn_time),
        .decay_rate (in.decay_rate),
        .thrust_x   (in.thrust_x),
        .thrust_y   (in.thrust_y),
        .thrust_z   (in.thrust_z),
        .mount_x    (in.mount_x),
        .mount_y    (in.mount_y),
        .mount_z    (in.mount_z),
        .last_one   (in.last_one),
        .sum_f      (sum_f),
        .sum_m      (sum_m)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.out_load)
            ov_reg <= 1'b1;
        else if (out.ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out.force_x  <= sum_f[0];
            out.force_y  <= sum_f[1];
            out.force_z  <= sum_f[2];
            out.moment_x <= sum_m[0];
            out.moment_y <= sum_m[1];
            out.moment_z <= sum_m[2];
        end
    end

    assign out.valid = ov_reg;

endmodule

`default_nettype wire
